// ===== hdl/ogru_pkg.sv =====
// Shared types, constants and functions for the occupancy grid ray update core.
package ogru_pkg;

    localparam int GRID_WIDTH_DEF  = 256;
    localparam int GRID_HEIGHT_DEF = 256;

    localparam logic signed [9:0] LO_MIN  = -10'sd400;
    localparam logic signed [9:0] LO_MAX  = 10'sd400;
    localparam logic signed [9:0] LO_FREE = -10'sd42;
    localparam logic signed [9:0] LO_OCC  = 10'sd85;

    localparam logic [1:0] ST_RAY_OK   = 2'd0;
    localparam logic [1:0] ST_RAY_DROP = 2'd1;
    localparam logic [1:0] ST_READ_OK  = 2'd2;
    localparam logic [1:0] ST_READ_OUT = 2'd3;

    localparam logic REQ_RAY  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [1:0] REG_CORNER_X  = 2'd0;
    localparam logic [1:0] REG_CORNER_Y  = 2'd1;
    localparam logic [1:0] REG_CELL_SIZE = 2'd2;

    // One request as it travels from the front end to the walker.
    typedef struct packed {
        logic                req_type;
        logic signed [24:0]  nx0;
        logic signed [24:0]  ny0;
        logic signed [24:0]  nx1;
        logic signed [24:0]  ny1;
        logic                hit;
        logic signed [10:0]  cell_x;
        logic signed [10:0]  cell_y;
    } ogru_req_t;

    // Occupancy percent of a log-odds value, from the sigmoid threshold table.
    function automatic logic signed [7:0] ogru_percent(input logic signed [9:0] v);
        logic [8:0] thr [48];
        logic [9:0] a;
        logic [6:0] p;
        thr = '{9'd3, 9'd7, 9'd11, 9'd15, 9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd39,
                9'd43, 9'd47, 9'd52, 9'd56, 9'd60, 9'd65, 9'd69, 9'd74, 9'd78, 9'd83,
                9'd88, 9'd92, 9'd97, 9'd103, 9'd108, 9'd113, 9'd119, 9'd124, 9'd130,
                9'd136, 9'd142, 9'd149, 9'd156, 9'd163, 9'd170, 9'd178, 9'd186,
                9'd195, 9'd205, 9'd215, 9'd226, 9'd238, 9'd252, 9'd267, 9'd285,
                9'd306, 9'd332, 9'd367};
        a = v[9] ? 10'(-v) : v;
        p = 7'd50;
        for (int k = 0; k < 48; k++) begin
            if (a >= {1'b0, thr[k]}) begin
                p = 7'(51 + k);
            end
        end
        if (v[9]) begin
            p = 7'd100 - p;
        end
        return signed'({1'b0, p});
    endfunction

endpackage

// ===== hdl/occupancy_grid_ray_update_core.sv =====
// Each ray takes four serial divisions on the shared divider, the grid check and the
// output stage, plus a memory read then write per walked cell; a read passes the
// read, wait, result and output states. Throughput is set by the shared divider
// and the grid walk. A two-entry request queue accepts new requests while the
// walker is busy. After reset the grid is cleared one cell a cycle, during which
// queued requests wait; configuration registers reset at once.
module occupancy_grid_ray_update_core #(
    parameter int GRID_WIDTH  = ogru_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ogru_pkg::GRID_HEIGHT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic signed [23:0] start_x,
    input  logic signed [23:0] start_y,
    input  logic signed [23:0] end_x,
    input  logic signed [23:0] end_y,
    input  logic               hit,
    input  logic signed [10:0] cell_x,
    input  logic signed [10:0] cell_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [7:0]  occupancy,
    output logic signed [9:0]  cell_log_odds
);
    import ogru_pkg::*;

    logic signed [23:0] corner_x_reg, corner_y_reg;
    logic [15:0]        cell_size_reg;
    logic               q_valid, q_pop;
    ogru_req_t          q_data;

    assign pready = 1'b1;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_x_reg  <= '0;
            corner_y_reg  <= '0;
            cell_size_reg <= 16'd13;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[3:2] == REG_CORNER_X)
            begin
                corner_x_reg <= pwdata[23:0];
            end
            else if (paddr[3:2] == REG_CORNER_Y)
            begin
                corner_y_reg <= pwdata[23:0];
            end
            else if (paddr[3:2] == REG_CELL_SIZE)
            begin
                cell_size_reg <= pwdata[15:0];
            end
        end
    end

    // Register reads.
    always_comb
    begin
        prdata = '0;
        if (paddr[3:2] == REG_CORNER_X)
        begin
            prdata = 32'(corner_x_reg);
        end
        else if (paddr[3:2] == REG_CORNER_Y)
        begin
            prdata = 32'(corner_y_reg);
        end
        else if (paddr[3:2] == REG_CELL_SIZE)
        begin
            prdata = {16'd0, cell_size_reg};
        end
    end

    ogru_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .start_x  (start_x),
        .start_y  (start_y),
        .end_x    (end_x),
        .end_y    (end_y),
        .hit      (hit),
        .cell_x   (cell_x),
        .cell_y   (cell_y),
        .corner_x (corner_x_reg),
        .corner_y (corner_y_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data)
    );

    ogru_back #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cell_size     (cell_size_reg),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_data        (q_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .occupancy     (occupancy),
        .cell_log_odds (cell_log_odds)
    );
endmodule

// ===== hdl/ogru_divider.sv =====
// Sequential signed floor divider, one quotient bit per cycle.
module ogru_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [24:0]  num,
    input  logic [15:0]         den,
    output logic                done,
    output logic signed [24:0]  quo
);
    logic [24:0] rem_reg, rem_next;
    logic [24:0] q_reg, q_next;
    logic [15:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [25:0] trial;
    logic [24:0] mag;

    assign mag = num[24] ? 25'(-num) : num;
    assign trial = {rem_reg, q_reg[24]} - {10'd0, den_reg};

    // Restoring division on the magnitude, then floor correction.
    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            q_next    = mag;
            den_next  = (den == 16'd0) ? 16'd1 : den;
            neg_next  = num[24];
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[25])
            begin
                rem_next = trial[24:0];
                q_next   = {q_reg[23:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[23:0], q_reg[24]};
                q_next   = {q_reg[23:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd24)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // Negative dividend with a remainder rounds one further down.
    assign done = done_reg;
    assign quo  = neg_reg ? ((rem_reg != '0) ? 25'(-q_reg - 25'd1) : 25'(-q_reg)) : q_reg;
endmodule

// ===== hdl/ogru_front.sv =====
// Front end: captures requests, offsets them by the origin and queues them.
module ogru_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic signed [23:0]    start_x,
    input  logic signed [23:0]    start_y,
    input  logic signed [23:0]    end_x,
    input  logic signed [23:0]    end_y,
    input  logic                  hit,
    input  logic signed [10:0]    cell_x,
    input  logic signed [10:0]    cell_y,
    input  logic signed [23:0]    corner_x,
    input  logic signed [23:0]    corner_y,
    output logic                  q_valid,
    input  logic                  q_pop,
    output ogru_pkg::ogru_req_t   q_data
);
    import ogru_pkg::*;

    localparam int QDEPTH = 2;

    ogru_req_t  mem_reg [QDEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    ogru_req_t  item;

    assign in_stall = (cnt_reg == 2'(QDEPTH));
    assign push     = in_valid && !in_stall;

    // Offsets from the grid corner, kept one bit wider.
    always_comb
    begin
        item.req_type = req_type;
        item.nx0      = 25'(start_x) - 25'(corner_x);
        item.ny0      = 25'(start_y) - 25'(corner_y);
        item.nx1      = 25'(end_x) - 25'(corner_x);
        item.ny1      = 25'(end_y) - 25'(corner_y);
        item.hit      = hit;
        item.cell_x   = cell_x;
        item.cell_y   = cell_y;
    end

    always_comb
    begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = q_pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= item;
        end
    end

    assign q_valid = (cnt_reg != '0);
    assign q_data  = mem_reg[rp_reg];
endmodule

// ===== hdl/ogru_back.sv =====
// Back end: divides to cells, walks the ray over the grid memory, serves reads.
module ogru_back #(
    parameter int GRID_WIDTH  = ogru_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ogru_pkg::GRID_HEIGHT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          cell_size,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  ogru_pkg::ogru_req_t  q_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic signed [7:0]    occupancy,
    output logic signed [9:0]    cell_log_odds
);
    import ogru_pkg::*;

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(CELLS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_DWAIT = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_WR    = 4'd6;
    localparam logic [3:0] S_RRD   = 4'd7;
    localparam logic [3:0] S_RRES  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_RWAIT = 4'd10;

    logic [3:0]          st_reg, st_next;
    logic [1:0]          didx_reg, didx_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic signed [24:0]  qv_reg [4];
    ogru_req_t           cur_reg;
    logic signed [12:0]  x_reg, y_reg, bx, by, ax, ay;
    logic signed [13:0]  dx_reg, dy_reg, err_reg;
    logic signed [13:0]  e2;
    logic                sx_reg, sy_reg;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          status_reg;
    logic signed [7:0]   occ_reg;
    logic signed [9:0]   lo_reg;
    logic signed [10:0]  mem_rd_reg;
    logic signed [10:0]  mem [CELLS];
    logic                we;
    logic [AW-1:0]       waddr, raddr;
    logic signed [10:0]  wdata;
    logic                div_start, div_done;
    logic signed [24:0]  div_num, div_q;
    logic                in_grid_ok, last_cell, rd_in;
    logic signed [10:0]  sum;
    logic signed [9:0]   delta, clamped;

    ogru_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (cell_size),
        .done  (div_done),
        .quo   (div_q)
    );

    always_comb
    begin
        unique case (didx_reg)
            2'd0:    div_num = cur_reg.nx0;
            2'd1:    div_num = cur_reg.ny0;
            2'd2:    div_num = cur_reg.nx1;
            default: div_num = cur_reg.ny1;
        endcase
    end

    function automatic logic ingrid(input logic signed [24:0] gx, input logic signed [24:0] gy);
        return !gx[24] && !gy[24] && (gx < 25'(GRID_WIDTH)) && (gy < 25'(GRID_HEIGHT));
    endfunction

    assign in_grid_ok = ingrid(qv_reg[0], qv_reg[1]) && ingrid(qv_reg[2], qv_reg[3]);
    assign ax = 13'(qv_reg[0]);
    assign ay = 13'(qv_reg[1]);
    assign bx = 13'(qv_reg[2]);
    assign by = 13'(qv_reg[3]);
    assign last_cell = (x_reg == bx) && (y_reg == by);
    assign e2 = 14'(err_reg <<< 1);
    assign rd_in = !cur_reg.cell_x[10] && !cur_reg.cell_y[10]
                   && (26'(cur_reg.cell_x) < 26'(GRID_WIDTH))
                   && (26'(cur_reg.cell_y) < 26'(GRID_HEIGHT));

    // Cell update: bit 10 of a stored word is the observed mark.
    assign delta   = (last_cell && cur_reg.hit) ? LO_OCC : LO_FREE;
    assign sum     = 11'(signed'(mem_rd_reg[9:0])) + 11'(delta);
    assign clamped = (sum < 11'(LO_MIN)) ? LO_MIN : ((sum > 11'(LO_MAX)) ? LO_MAX : 10'(sum));

    always_comb
    begin
        raddr = (st_reg == S_RRD || st_reg == S_RWAIT)
                ? AW'(32'(cur_reg.cell_y) * GRID_WIDTH + 32'(cur_reg.cell_x))
                : AW'(32'(y_reg) * GRID_WIDTH + 32'(x_reg));
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = AW'(32'(y_reg) * GRID_WIDTH + 32'(x_reg));
        wdata = {1'b1, clamped};
        if (st_reg == S_CLR)
        begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = '0;
        end
        else if (st_reg == S_WR)
        begin
            we = 1'b1;
        end
    end

    // Grid memory, one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        mem_rd_reg <= mem[raddr];
    end

    // Sequencer.
    always_comb
    begin
        st_next        = st_reg;
        didx_next      = didx_reg;
        clr_next       = clr_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (st_reg)
            S_CLR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(CELLS - 1))
                begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    didx_next = 2'd0;
                    st_next = (q_data.req_type == REQ_READ) ? S_RRD : S_DIV;
                end
            end
            S_DIV:
            begin
                div_start = 1'b1;
                st_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    didx_next = didx_reg + 2'd1;
                    st_next = (didx_reg == 2'd3) ? S_CHECK : S_DIV;
                end
            end
            S_CHECK:
            begin
                st_next = in_grid_ok ? S_RD : S_OUT;
            end
            S_RD:    st_next = S_WR;
            S_WR:    st_next = last_cell ? S_OUT : S_RD;
            S_RRD:   st_next = S_RWAIT;
            S_RWAIT: st_next = S_RRES;
            S_RRES:  st_next = S_OUT;
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_CLR;
            didx_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            didx_reg      <= didx_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        if (st_reg == S_DWAIT && div_done)
        begin
            qv_reg[didx_reg] <= div_q;
        end
        if (st_reg == S_CHECK)
        begin
            x_reg   <= ax;
            y_reg   <= ay;
            dx_reg  <= (bx > ax) ? 14'(bx - ax) : 14'(ax - bx);
            dy_reg  <= (by > ay) ? 14'(ay - by) : 14'(by - ay);
            err_reg <= ((bx > ax) ? 14'(bx - ax) : 14'(ax - bx))
                       + ((by > ay) ? 14'(ay - by) : 14'(by - ay));
            sx_reg  <= ax < bx;
            sy_reg  <= ay < by;
            status_reg <= in_grid_ok ? ST_RAY_OK : ST_RAY_DROP;
            occ_reg <= '0;
            lo_reg  <= '0;
        end
        if (st_reg == S_WR && !last_cell)
        begin
            err_reg <= err_reg + ((e2 >= dy_reg) ? dy_reg : 14'd0)
                       + ((e2 <= dx_reg) ? dx_reg : 14'd0);
            if (e2 >= dy_reg)
            begin
                x_reg <= sx_reg ? x_reg + 13'sd1 : x_reg - 13'sd1;
            end
            if (e2 <= dx_reg)
            begin
                y_reg <= sy_reg ? y_reg + 13'sd1 : y_reg - 13'sd1;
            end
        end
        if (st_reg == S_RRES)
        begin
            if (rd_in)
            begin
                status_reg <= ST_READ_OK;
                lo_reg     <= mem_rd_reg[9:0];
                occ_reg    <= mem_rd_reg[10] ? ogru_percent(mem_rd_reg[9:0]) : -8'sd1;
            end
            else
            begin
                status_reg <= ST_READ_OUT;
                lo_reg     <= '0;
                occ_reg    <= 8'sd50;
            end
        end
        if (st_reg == S_OUT && (!out_valid_reg || !out_stall))
        begin
            status        <= status_reg;
            occupancy     <= occ_reg;
            cell_log_odds <= lo_reg;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

// ===== hdl/ogru_checker.sv =====
// Port-level checker for the occupancy grid ray update core, with its bind.
module ogru_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [1:0]        status,
    input logic signed [7:0] occupancy,
    input logic signed [9:0] cell_log_odds,
    input logic              pready
);
    import ogru_pkg::*;

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("result changed while stalled");

    // Ray results carry zero payload fields.
    a_ray: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_RAY_OK || status == ST_RAY_DROP)
        |-> occupancy == 8'sd0 && cell_log_odds == 10'sd0)
        else $error("ray result with payload");

    // Outside reads report even odds.
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_READ_OUT |-> occupancy == 8'sd50 && cell_log_odds == 10'sd0)
        else $error("bad outside read");

    // Reported log-odds stay within the clamp and pready stays high.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cell_log_odds >= LO_MIN && cell_log_odds <= LO_MAX && pready)
        else $error("log-odds out of range");
endmodule

bind occupancy_grid_ray_update_core ogru_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .occupancy     (occupancy),
    .cell_log_odds (cell_log_odds),
    .pready        (pready)
);
